/* hdl/tspf_pkg.sv */
`default_nettype none

package tspf_pkg;

  localparam int unsigned PidSlotsDef = 16;
  localparam int unsigned PktLen      = 188;
  localparam int unsigned DlyAddrW    = $clog2(PktLen);

  localparam logic [7:0]  SyncByte   = 8'h47;
  localparam logic [7:0]  PktLenB    = 8'(PktLen);
  localparam logic [24:0] BufSizeRst = 25'd1048576;

  typedef enum logic [1:0] {
    CmdData     = 2'd0,
    CmdMapPid   = 2'd1,
    CmdClrTable = 2'd2,
    CmdClrBuf   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  data_byte;
    logic [12:0] pid_value;
  } in_req_t;

  typedef struct packed {
    logic        store_valid;
    logic [23:0] store_addr;
    logic [7:0]  store_byte;
    logic [24:0] buffer_used;
    logic [31:0] sync_searches;
    logic [31:0] hunts_failed;
    logic        map_full;
    logic        sync_locked;
    logic [4:0]  pid_entries;
  } out_req_t;

  typedef struct packed {
    logic        map;
    logic        clear;
    logic [12:0] pid;
  } tbl_req_t;

endpackage

`default_nettype wire

/* hdl/tspf_ram.sv */
`default_nettype none

module tspf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 188
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/tspf_pid_table.sv */
`default_nettype none

module tspf_pid_table #(
  parameter int unsigned Slots = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tspf_pkg::tbl_req_t         req_i,
  input  wire logic [12:0]                lookup_pid_i,
  output      logic                       hit_o,
  output      logic [$clog2(Slots+1)-1:0] used_o
);

  import tspf_pkg::*;

  localparam int unsigned CntW = $clog2(Slots + 1);
  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;

  logic [12:0]     table_q [Slots];
  logic [CntW-1:0] used_q, used_d;
  logic            full;

  assign full   = (used_q == CntW'(Slots));
  assign used_o = used_q;

  always_comb begin
    used_d = used_q;
    if (req_i.clear) begin
      used_d = '0;
    end else if (req_i.map && !full) begin
      used_d = used_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.map && !full && !req_i.clear) begin
      table_q[used_q[IdxW-1:0]] <= req_i.pid;
    end
  end

  // parallel compare across every slot in use
  always_comb begin
    hit_o = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      if ((CntW'(i) < used_q) && (table_q[i] == lookup_pid_i)) begin
        hit_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/tspf_out_buf.sv */
`default_nettype none

module tspf_out_buf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire tspf_pkg::out_req_t data_i,
  output      logic               ready_o,
  output      logic               valid_o,
  output      tspf_pkg::out_req_t data_o,
  input  wire logic               ready_i
);

  import tspf_pkg::*;

  logic     out_valid_q, skid_valid_q;
  out_req_t out_q, skid_q;
  logic     drain;

  assign drain   = !out_valid_q || ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (drain) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push_i;
      end else begin
        out_valid_q  <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push_i) begin
          skid_q <= data_i;
        end
      end else if (push_i) begin
        out_q <= data_i;
      end
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/ts_packet_pid_filter_top.sv */
// Transport-stream PID filter.
// Requests enter on in_valid_i/in_ready_o: a stream byte, a PID to map, a
// table clear or a buffer clear. Every accepted request gives one result on
// out_valid_o/out_ready_i, carrying the buffer write (if any) and status.
// Throughput: one request per clock while in_ready_o is high. The delay
// line is a 188-entry RAM read three entries ahead of the write pointer,
// so its registered read is hidden and bytes can enter back to back.
// The result is registered in the output stage before it is offered.
// When the receiver stalls, a second result is held in a skid stage, so one
// more request is taken; in_ready_o drops only while both stages are full.
// Reset empties the PID table and the output stages, clears lock, hunt and
// fill state and the counters, and sets buffer_size to 1048576. The delay
// line RAM needs no clearing pass: 188 bytes are written before any read
// data is used. buffer_size is written by cfg_we_i/cfg_wdata_i; the user
// must write it only while the block is idle; the block does not enforce it.
`default_nettype none

module ts_packet_pid_filter_top #(
  parameter int unsigned PidSlots = tspf_pkg::PidSlotsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire tspf_pkg::in_req_t  in_req_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      tspf_pkg::out_req_t out_req_o,
  input  wire logic               cfg_we_i,
  input  wire logic [24:0]        cfg_wdata_i
);

  import tspf_pkg::*;

  localparam int unsigned CntW = $clog2(PidSlots + 1);

  logic [24:0]         bsize_q;
  logic [DlyAddrW-1:0] head_q, head_d, head_inc, rd_addr;
  logic [8:0]          head_p3;
  logic [7:0]          prime_q, prime_d;
  logic                lock_q, lock_d;
  logic [7:0]          pos_q, pos_d;
  logic                keep_q, keep_d;
  logic [7:0]          hunt_q, hunt_d;
  logic [24:0]         fill_q, fill_d;
  logic [31:0]         search_q, search_d;
  logic [31:0]         fail_q, fail_d;
  logic [7:0]          la0_q, la0_d, la1_q, la1_d;
  logic [7:0]          ram_rdata;
  logic                ram_we;
  logic                accept;
  logic                tbl_hit;
  logic [CntW-1:0]     tbl_used, used_nxt;
  logic                tbl_full, tbl_empty;
  tbl_req_t            tbl_req;
  out_req_t            res;
  logic                sv, mfull, start, filt;
  logic                room_one, room_pkt;

  assign accept    = in_valid_i && in_ready_o;
  assign tbl_full  = (tbl_used == CntW'(PidSlots));
  assign tbl_empty = (tbl_used == '0);
  assign room_one  = ({1'b0, fill_q} + 26'd1) < {1'b0, bsize_q};
  assign room_pkt  = ({1'b0, fill_q} + 26'(PktLen)) < {1'b0, bsize_q};

  assign head_inc = (head_q == DlyAddrW'(PktLen - 1)) ? '0 : head_q + DlyAddrW'(1);
  assign head_p3  = {1'b0, head_q} + 9'd3;
  assign rd_addr  = (head_p3 >= 9'(PktLen)) ? DlyAddrW'(head_p3 - 9'(PktLen))
                                            : DlyAddrW'(head_p3);

  tspf_ram #(
    .Width(8),
    .Depth(PktLen)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(head_q),
    .wdata_i(in_req_i.data_byte),
    .re_i   (ram_we),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  tspf_pid_table #(
    .Slots(PidSlots)
  ) u_pid_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (tbl_req),
    .lookup_pid_i({la1_q[4:0], ram_rdata}),
    .hit_o       (tbl_hit),
    .used_o      (tbl_used)
  );

  always_comb begin
    head_d   = head_q;
    prime_d  = prime_q;
    lock_d   = lock_q;
    pos_d    = pos_q;
    keep_d   = keep_q;
    hunt_d   = hunt_q;
    fill_d   = fill_q;
    search_d = search_q;
    fail_d   = fail_q;
    la0_d    = la0_q;
    la1_d    = la1_q;
    ram_we   = 1'b0;
    tbl_req  = '0;
    sv       = 1'b0;
    mfull    = 1'b0;
    start    = 1'b0;
    filt     = 1'b0;
    used_nxt = tbl_used;
    tbl_req.pid = in_req_i.pid_value;
    if (accept) begin
      case (in_req_i.cmd)
        CmdMapPid: begin
          if (tbl_full) begin
            mfull = 1'b1;
          end else begin
            tbl_req.map = 1'b1;
            used_nxt    = tbl_used + CntW'(1);
          end
        end
        CmdClrTable: begin
          tbl_req.clear = 1'b1;
          used_nxt      = '0;
          head_d        = '0;
          prime_d       = '0;
          lock_d        = 1'b0;
          pos_d         = '0;
          keep_d        = 1'b0;
          hunt_d        = '0;
        end
        CmdClrBuf: begin
          fill_d = '0;
          keep_d = 1'b0;
        end
        default: begin
          if (tbl_empty) begin
            if (room_one) begin
              sv     = 1'b1;
              fill_d = fill_q + 25'd1;
            end
          end else begin
            filt   = 1'b1;
            ram_we = 1'b1;
            la0_d  = la1_q;
            la1_d  = ram_rdata;
            head_d = head_inc;
            if (prime_q != PktLenB) begin
              prime_d = prime_q + 8'd1;
            end else begin
              if (!lock_q) begin
                if (la0_q == SyncByte && in_req_i.data_byte == SyncByte) begin
                  lock_d = 1'b1;
                  hunt_d = '0;
                  start  = 1'b1;
                end else if (hunt_q + 8'd1 >= PktLenB) begin
                  hunt_d = '0;
                  fail_d = fail_q + 32'd1;
                end else begin
                  hunt_d = hunt_q + 8'd1;
                end
              end else if (pos_q == '0) begin
                if (la0_q == SyncByte) begin
                  start = 1'b1;
                end else begin
                  // lost lock: this byte opens a new hunt
                  lock_d   = 1'b0;
                  keep_d   = 1'b0;
                  search_d = search_q + 32'd1;
                  hunt_d   = 8'd1;
                end
              end
              if (start) begin
                keep_d = tbl_hit && room_pkt;
                pos_d  = '0;
              end
              if (lock_d) begin
                if (keep_d) begin
                  sv     = 1'b1;
                  fill_d = fill_q + 25'd1;
                end
                pos_d = pos_d + 8'd1;
                if (pos_d == PktLenB) begin
                  pos_d  = '0;
                  keep_d = 1'b0;
                end
              end
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    res               = '0;
    res.store_valid   = sv;
    res.store_addr    = sv ? fill_q[23:0] : 24'd0;
    res.store_byte    = sv ? (filt ? la0_q : in_req_i.data_byte) : 8'd0;
    res.buffer_used   = fill_d;
    res.sync_searches = search_d;
    res.hunts_failed  = fail_d;
    res.map_full      = mfull;
    res.sync_locked   = lock_d;
    res.pid_entries   = 5'(used_nxt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q  <= BufSizeRst;
      head_q   <= '0;
      prime_q  <= '0;
      lock_q   <= 1'b0;
      pos_q    <= '0;
      keep_q   <= 1'b0;
      hunt_q   <= '0;
      fill_q   <= '0;
      search_q <= '0;
      fail_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        bsize_q <= cfg_wdata_i;
      end
      head_q   <= head_d;
      prime_q  <= prime_d;
      lock_q   <= lock_d;
      pos_q    <= pos_d;
      keep_q   <= keep_d;
      hunt_q   <= hunt_d;
      fill_q   <= fill_d;
      search_q <= search_d;
      fail_q   <= fail_d;
    end
  end

  // look-ahead of the next bytes to leave the delay line
  always_ff @(posedge clk_i) begin
    la0_q <= la0_d;
    la1_q <= la1_d;
  end

  tspf_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (res),
    .ready_o(in_ready_o),
    .valid_o(out_valid_o),
    .data_o (out_req_o),
    .ready_i(out_ready_i)
  );

`ifndef ASSERT_OFF
  a_lock_needs_pids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q |-> !tbl_empty)
    else $error("sync lock held with an empty PID table");

  a_keep_needs_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keep_q |-> lock_q)
    else $error("packet kept without sync lock");

  a_pos_needs_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != '0) |-> lock_q)
    else $error("packet position advanced without sync lock");

  a_store_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.store_valid) |->
      (out_req_o.store_addr == 24'(out_req_o.buffer_used - 25'd1)))
    else $error("store address does not match fill pointer");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("skid stage full while output stage empty");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import tspf_pkg::*;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_req_t want;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_req_t     in_req    = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_req_t    out_req;
  logic        cfg_we    = 1'b0;
  logic [24:0] cfg_wdata = '0;

  // Filter state as seen by the predictor
  logic [7:0]  dly_line [PktLen];
  int unsigned dly_head, prime_cnt, pid_cnt, pkt_pos, hunt_cnt;
  logic [12:0] pid_tab [PidSlotsDef];
  bit          locked, keep;
  logic [24:0] fill, buf_size;
  logic [31:0] lost_syncs, failed_hunts;

  out_req_t    pending_outs [$];
  dir_row_t    dir_tab [$];
  int unsigned mismatches = 0;
  bit          gaps_on = 1'b1;
  bit          steady = 1'b0;
  bit          hold_ask = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  ts_packet_pid_filter_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #10 clk = ~clk;

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic void drop_sync();
    for (int i = 0; i < PktLen; i++) dly_line[i] = 8'h00;
    dly_head  = 0;
    prime_cnt = 0;
    locked    = 1'b0;
    pkt_pos   = 0;
    keep      = 1'b0;
    hunt_cnt  = 0;
  endfunction

  function automatic void bump_hunt();
    hunt_cnt++;
    if (hunt_cnt >= PktLen) begin
      hunt_cnt = 0;
      failed_hunts++;
    end
  endfunction

  function automatic out_req_t filter_step(input in_req_t r);
    out_req_t    o;
    logic [7:0]  leaving, n1, n2;
    logic [12:0] pid;
    int unsigned h;
    bit          primed, start, hit;
    o = '0;
    case (r.cmd)
      CmdMapPid: begin
        if (pid_cnt < PidSlotsDef) begin
          pid_tab[pid_cnt] = r.pid_value;
          pid_cnt++;
        end else begin
          o.map_full = 1'b1;
        end
      end
      CmdClrTable: begin
        pid_cnt = 0;
        drop_sync();
      end
      CmdClrBuf: begin
        fill = '0;
        keep = 1'b0;
      end
      default: begin
        if (pid_cnt == 0) begin
          if ({7'd0, fill} + 32'd1 < {7'd0, buf_size}) begin
            o.store_valid = 1'b1;
            o.store_addr  = fill[23:0];
            o.store_byte  = r.data_byte;
            fill          = fill + 25'd1;
          end
        end else begin
          h       = dly_head;
          leaving = dly_line[h];
          n1      = dly_line[(h + 1) % PktLen];
          n2      = dly_line[(h + 2) % PktLen];
          primed  = prime_cnt >= PktLen;
          start   = 1'b0;
          dly_line[h] = r.data_byte;
          dly_head    = (h + 1) % PktLen;
          if (prime_cnt < PktLen) prime_cnt++;
          if (primed) begin
            if (!locked) begin
              if (leaving == SyncByte && r.data_byte == SyncByte) begin
                locked   = 1'b1;
                hunt_cnt = 0;
                start    = 1'b1;
              end else begin
                bump_hunt();
              end
            end else if (pkt_pos == 0) begin
              if (leaving == SyncByte) begin
                start = 1'b1;
              end else begin
                locked = 1'b0;
                keep   = 1'b0;
                lost_syncs++;
                hunt_cnt = 0;
                bump_hunt();
              end
            end
            if (start) begin
              pid = {n1[4:0], n2};
              hit = 1'b0;
              for (int i = 0; i < pid_cnt; i++) if (pid_tab[i] == pid) hit = 1'b1;
              keep    = hit && ({7'd0, fill} + PktLen < {7'd0, buf_size});
              pkt_pos = 0;
            end
            if (locked) begin
              if (keep) begin
                o.store_valid = 1'b1;
                o.store_addr  = fill[23:0];
                o.store_byte  = leaving;
                fill          = fill + 25'd1;
              end
              pkt_pos++;
              if (pkt_pos >= PktLen) begin
                pkt_pos = 0;
                keep    = 1'b0;
              end
            end
          end
        end
      end
    endcase
    o.buffer_used   = fill;
    o.sync_searches = lost_syncs;
    o.hunts_failed  = failed_hunts;
    o.sync_locked   = locked;
    o.pid_entries   = pid_cnt[4:0];
    return o;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Result side: check, then choose next ready
  always @(posedge clk) begin : rx
    out_req_t want;
    if (out_valid && out_ready) begin
      if (pending_outs.size() == 0) begin
        flag_error($sformatf("unexpected result %h", out_req));
      end else begin
        want = pending_outs.pop_front();
        cmp_field("store_valid", out_req.store_valid, want.store_valid);
        cmp_field("store_addr", out_req.store_addr, want.store_addr);
        cmp_field("store_byte", out_req.store_byte, want.store_byte);
        cmp_field("buffer_used", out_req.buffer_used, want.buffer_used);
        cmp_field("sync_searches", out_req.sync_searches, want.sync_searches);
        cmp_field("hunts_failed", out_req.hunts_failed, want.hunts_failed);
        cmp_field("map_full", out_req.map_full, want.map_full);
        cmp_field("sync_locked", out_req.sync_locked, want.sync_locked);
        cmp_field("pid_entries", out_req.pid_entries, want.pid_entries);
      end
    end
    if (hold_ask && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 60;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_req(input in_req_t r, input bit typed, input out_req_t want);
    out_req_t pred;
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = filter_step(r);
    pending_outs.push_back(typed ? want : pred);
    if (gaps_on && !steady && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_req(in_req_t'{cmd: CmdData, data_byte: b, pid_value: 13'($urandom)}, 1'b0, '0);
  endtask

  task automatic send_cmd(input cmd_e c, input logic [12:0] p);
    send_req(in_req_t'{cmd: c, data_byte: 8'($urandom), pid_value: p}, 1'b0, '0);
  endtask

  task automatic set_buffer_size(input logic [24:0] v);
    in_valid <= 1'b0;
    while (pending_outs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    buf_size = v;
  endtask

  task automatic send_packet(input logic [12:0] pid, input bit bad_sync);
    logic [7:0] b;
    for (int k = 0; k < PktLen; k++) begin
      b = 8'($urandom);
      if (k == 0) begin
        if (!bad_sync) b = SyncByte;
        else if (b == SyncByte) b = ~b;
      end else if (k == 1) begin
        b = {3'($urandom), pid[12:8]};
      end else if (k == 2) begin
        b = pid[7:0];
      end
      if ($urandom_range(0, 499) == 0) send_cmd(CmdClrBuf, 13'($urandom));
      else if ($urandom_range(0, 999) == 0) send_cmd(CmdMapPid, pid);
      send_byte(b);
    end
  endtask

  task automatic run_filtered();
    logic [12:0] mapped [$];
    logic [12:0] pid;
    int unsigned nmap, junk;
    send_cmd(CmdClrTable, 13'($urandom));
    nmap = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 18) : $urandom_range(1, 4);
    repeat (nmap) begin
      case ($urandom_range(0, 5))
        0:       pid = 13'h0000;
        1:       pid = 13'h1fff;
        default: pid = 13'($urandom);
      endcase
      mapped.push_back(pid);
      send_cmd(CmdMapPid, pid);
    end
    junk = $urandom_range(0, 8);
    repeat (junk) send_byte(8'($urandom));
    // first packet fills the delay line and is stored while the second arrives
    send_packet(mapped[$urandom_range(0, mapped.size() - 1)], 1'b0);
    if ($urandom_range(0, 3) != 0) pid = mapped[$urandom_range(0, mapped.size() - 1)];
    else pid = 13'($urandom);
    send_packet(pid, $urandom_range(0, 11) == 0);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
  endtask

  task automatic run_plain();
    send_cmd(CmdClrTable, 13'($urandom));
    repeat ($urandom_range(2, 4)) begin
      case ($urandom_range(0, 29))
        0:       send_cmd(CmdClrBuf, 13'($urandom));
        1:       send_cmd(CmdClrTable, 13'($urandom));
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  function automatic out_req_t plain_out(input bit sv, input logic [23:0] a,
                                         input logic [7:0] b, input logic [24:0] used,
                                         input bit full, input logic [4:0] n);
    out_req_t o;
    o             = '0;
    o.store_valid = sv;
    o.store_addr  = a;
    o.store_byte  = b;
    o.buffer_used = used;
    o.map_full    = full;
    o.pid_entries = n;
    return o;
  endfunction

  function automatic dir_row_t row(input cmd_e c, input logic [7:0] b, input logic [12:0] p,
                                   input out_req_t w);
    dir_row_t d;
    d.req   = in_req_t'{cmd: c, data_byte: b, pid_value: p};
    d.typed = 1'b1;
    d.want  = w;
    return d;
  endfunction

  initial begin : stim
    logic [24:0] sizes [8];
    drop_sync();
    pid_cnt      = 0;
    fill         = '0;
    lost_syncs   = '0;
    failed_hunts = '0;
    buf_size     = BufSizeRst;

    sizes = '{BufSizeRst, 25'd0, 25'd1, 25'd2, 25'd376, 25'd377,
              25'($urandom_range(189, 2000)), 25'd16777216};

    dir_tab.push_back(row(CmdData, 8'h00, 13'h1fff, plain_out(1, 0, 8'h00, 1, 0, 0)));
    dir_tab.push_back(row(CmdData, 8'hff, 13'h0000, plain_out(1, 1, 8'hff, 2, 0, 0)));
    dir_tab.push_back(row(CmdClrBuf, 8'hff, 13'h1fff, plain_out(0, 0, 8'h00, 0, 0, 0)));
    dir_tab.push_back(row(CmdData, 8'h47, 13'h1fff, plain_out(1, 0, 8'h47, 1, 0, 0)));
    dir_tab.push_back(row(CmdMapPid, 8'hff, 13'h1fff, plain_out(0, 0, 8'h00, 1, 0, 1)));
    dir_tab.push_back(row(CmdMapPid, 8'h00, 13'h0000, plain_out(0, 0, 8'h00, 1, 0, 2)));
    // same PID again takes another slot
    dir_tab.push_back(row(CmdMapPid, 8'hff, 13'h0000, plain_out(0, 0, 8'h00, 1, 0, 3)));
    for (int i = 4; i <= 16; i++)
      dir_tab.push_back(row(CmdMapPid, 8'($urandom), 13'($urandom),
                            plain_out(0, 0, 8'h00, 1, 0, 5'(i))));
    dir_tab.push_back(row(CmdMapPid, 8'h00, 13'h0abc, plain_out(0, 0, 8'h00, 1, 1, 16)));
    // delay line still priming: nothing stored
    dir_tab.push_back(row(CmdData, 8'h47, 13'h0000, plain_out(0, 0, 8'h00, 1, 0, 16)));
    dir_tab.push_back(row(CmdClrTable, 8'hff, 13'h1fff, plain_out(0, 0, 8'h00, 1, 0, 0)));
    dir_tab.push_back(row(CmdClrBuf, 8'h00, 13'h0000, plain_out(0, 0, 8'h00, 0, 0, 0)));
    dir_tab.push_back(row(CmdData, 8'hff, 13'h1fff, plain_out(1, 0, 8'hff, 1, 0, 0)));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

    for (int p = 0; p < 8; p++) begin
      if (p > 0) set_buffer_size(sizes[p]);
      if (p == 7) steady = 1'b1;
      if (p == 2) hold_ask = 1'b1;
      gaps_on = $urandom_range(0, 3) != 0;
      send_cmd(CmdClrBuf, 13'($urandom));
      if (p == 0) run_filtered();
      run_plain();
    end

    in_valid <= 1'b0;
    while (pending_outs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
